// ===== src/ctrv_pkg.sv =====
// ----------------------------------------------------------------------------
// ctrv_pkg
// Shared constants, types and helper functions for the CTRV pose predictor.
// ----------------------------------------------------------------------------
package ctrv_pkg;

    // CORDIC depth and table
    localparam int TRIG_STAGES  = 16;
    localparam int ATAN_ENTRIES = 24;

    // datapath widths
    localparam int TW    = 34;           // trig values, Q2.30 with headroom
    localparam int MW    = 33 + TW;      // straight-move product
    localparam int PW    = 16 + TW + 1;  // arc numerator product
    localparam int NW    = 48;           // numerator magnitude / quotient bits
    localparam int DW    = 25;           // divisor magnitude bits
    localparam int SW    = NW + 2;       // position sum before saturation
    localparam int IN_W  = 112;
    localparam int OUT_W = 80;

    // angle constants in Q3.13
    localparam int PI_Q13      = 25736;
    localparam int TWO_PI_Q13  = 51472;
    localparam int HALF_PI_Q13 = 12868;

    localparam logic signed [15:0] TR_STRAIGHT   = 16'sd8;
    localparam logic [15:0]        STEP_TIME_RST = 16'd6554;
    localparam logic [31:0]        CORDIC_START  = 32'h26DD3B6A;

    localparam logic signed [SW-1:0] SUM_MAX = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0] SUM_MIN = SW'(-64'sd2147483648);
    localparam logic signed [MW-1:0] RND38   = MW'(64'sd137438953472);

    // truncated Q2.30 arctangent of 2^-i
    localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [15:0] h;
        logic signed [15:0] v;
        logic signed [15:0] tr;
    } t_in;

    typedef struct packed {
        t_in                in;
        logic signed [32:0] trdt;
        logic signed [32:0] p;
        logic               straight;
    } t_s1;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [15:0] v;
        logic signed [15:0] tr;
        logic signed [32:0] p;
        logic               straight;
        logic signed [19:0] sum;
        logic signed [15:0] hw;
    } t_s2;

    // fields fixed once the new heading is known
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [15:0] nh;
        logic signed [15:0] v;
        logic signed [15:0] tr;
        logic signed [32:0] p;
        logic               straight;
    } t_side;

    typedef struct packed {
        t_side              sd;
        logic signed [TW-1:0] z1;
        logic               flip1;
    } t_s3;

    typedef struct packed {
        logic signed [TW-1:0] x;
        logic signed [TW-1:0] y;
        logic signed [TW-1:0] z;
    } t_rot;

    typedef struct packed {
        t_side sd;
        t_rot  r1;
        t_rot  r2;
        logic  flip1;
        logic  flip2;
    } t_cord;

    typedef struct packed {
        logic signed [TW-1:0] z;
        logic                 flip;
    } t_fold;

    typedef struct packed {
        logic [DW-1:0] rem;
        logic [NW-1:0] num;
        logic [NW-1:0] quo;
    } t_dq;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [15:0] nh;
        logic               straight;
        logic signed [31:0] dxs;
        logic signed [31:0] dys;
        logic               negx;
        logic               negy;
        logic [DW-1:0]      dmag;
        t_dq                qx;
        t_dq                qy;
    } t_dv;

    // wrap into [-pi, pi); input within one turn of that range
    function automatic logic signed [15:0] wrap_q13(input logic signed [19:0] a);
        logic signed [20:0] t;
        t = 21'(a) + 21'(PI_Q13);
        if (t < 0) begin
            t = t + 21'(TWO_PI_Q13);
        end else if (t >= 21'(TWO_PI_Q13)) begin
            t = t - 21'(TWO_PI_Q13);
        end
        return 16'(t - 21'(PI_Q13));
    endfunction

    // fold into [-pi/2, pi/2] and scale to Q2.30
    function automatic t_fold fold_q13(input logic signed [15:0] a);
        t_fold             r;
        logic signed [15:0] f;
        f      = a;
        r.flip = 1'b0;
        if (a > 16'(HALF_PI_Q13)) begin
            f      = a - 16'(PI_Q13);
            r.flip = 1'b1;
        end else if (a < -16'(HALF_PI_Q13)) begin
            f      = a + 16'(PI_Q13);
            r.flip = 1'b1;
        end
        r.z = TW'(f) <<< 17;
        return r;
    endfunction

    // one CORDIC rotation step
    function automatic t_rot rot_step(input t_rot a, input int sh, input logic [31:0] at);
        t_rot                 r;
        logic signed [TW-1:0] xs;
        logic signed [TW-1:0] ys;
        logic signed [TW-1:0] ats;
        xs  = a.x >>> sh;
        ys  = a.y >>> sh;
        ats = $signed(TW'(at));
        if (a.z >= 0) begin
            r.x = a.x - ys;
            r.y = a.y + xs;
            r.z = a.z - ats;
        end else begin
            r.x = a.x + ys;
            r.y = a.y - xs;
            r.z = a.z + ats;
        end
        return r;
    endfunction

    // one restoring division step
    function automatic t_dq div_step(input t_dq a, input logic [DW-1:0] d);
        t_dq         r;
        logic [DW:0] trial;
        trial = {a.rem, a.num[NW-1]};
        r.num = {a.num[NW-2:0], 1'b0};
        if (trial >= {1'b0, d}) begin
            r.rem = DW'(trial - {1'b0, d});
            r.quo = {a.quo[NW-2:0], 1'b1};
        end else begin
            r.rem = trial[DW-1:0];
            r.quo = {a.quo[NW-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
        if (v > SUM_MAX) begin
            return 32'sh7FFF_FFFF;
        end else if (v < SUM_MIN) begin
            return 32'sh8000_0000;
        end
        return 32'(v);
    endfunction

endpackage

// ===== src/ctrv_pose_predict_unit.sv =====
// ----------------------------------------------------------------------------
// ctrv_pose_predict_unit
// Constant turn rate and velocity pose prediction, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream carries one pose request per beat: pos_x, pos_y, heading,
//    speed and turn_rate. Master stream returns new_x, new_y, new_heading.
//  - step_time is written through i_cfg_we / i_cfg_wdata while idle.
//  - One request is accepted per cycle while the pipeline is not stalled. A result
//    passes through five front stages, one stage per CORDIC rotation, three
//    product stages, one stage per quotient bit of the 48-bit restoring divider
//    and two output stages.
//  - The whole pipeline moves on one shared enable; when the receiver holds
//    off a valid result, the pipeline and o_s_axis_tready stall together,
//    nothing is lost or repeated, and the held result stays stable.
//  - Synchronous reset clears all valid bits and loads step_time = 6554.
//  - Two CORDIC rotators (old and new heading) and two dividers (x and y)
//    run side by side; small turn rates select the straight-line products.
// ----------------------------------------------------------------------------
module ctrv_pose_predict_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [15:0]                  i_cfg_wdata,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // pos_x[31:0], pos_y[63:32], heading[79:64], speed[95:80], turn_rate[111:96]
    input  logic [ctrv_pkg::IN_W-1:0]    i_s_axis_tdata,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // new_x[31:0], new_y[63:32], new_heading[79:64]
    output logic [ctrv_pkg::OUT_W-1:0]   o_m_axis_tdata
);
    import ctrv_pkg::*;

    // valid bit positions along the pipe
    localparam int V_S4  = 4;
    localparam int V_CD  = V_S4 + 1;
    localparam int V_E   = V_CD + TRIG_STAGES;
    localparam int V_F   = V_E + 1;
    localparam int V_G   = V_F + 1;
    localparam int V_DV  = V_G + 1;
    localparam int V_H   = V_DV + NW;
    localparam int V_O   = V_H + 1;
    localparam int NST   = V_O + 1;

    logic [15:0]    r_step_time;
    logic [NST-1:0] r_vld;
    logic           adv;

    // step time register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_time <= STEP_TIME_RST;
        end else if (i_cfg_we) begin
            r_step_time <= i_cfg_wdata;
        end
    end

    // shared enable: move unless a finished result is held off
    assign adv             = !r_vld[V_O] || i_m_axis_tready;
    assign o_s_axis_tready = adv;
    assign o_m_axis_tvalid = r_vld[V_O];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NST-2:0], i_s_axis_tvalid};
        end
    end

    // stage 0: capture request
    t_in r_s0;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0.px <= $signed(i_s_axis_tdata[31:0]);
            r_s0.py <= $signed(i_s_axis_tdata[63:32]);
            r_s0.h  <= $signed(i_s_axis_tdata[79:64]);
            r_s0.v  <= $signed(i_s_axis_tdata[95:80]);
            r_s0.tr <= $signed(i_s_axis_tdata[111:96]);
        end
    end

    // stage 1: turn and distance products
    t_s1 r_s1;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1.in       <= r_s0;
            r_s1.trdt     <= r_s0.tr * $signed({1'b0, r_step_time});
            r_s1.p        <= r_s0.v * $signed({1'b0, r_step_time});
            r_s1.straight <= (r_s0.tr >= -TR_STRAIGHT) && (r_s0.tr <= TR_STRAIGHT);
        end
    end

    // stage 2: rounded heading change, wrap old heading
    t_s2                r_s2;
    logic signed [33:0] dh_rnd;
    logic signed [17:0] dh;
    always_comb begin
        dh_rnd = 34'(r_s1.trdt) + 34'sd32768;
        dh     = 18'(dh_rnd >>> 16);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2.px       <= r_s1.in.px;
            r_s2.py       <= r_s1.in.py;
            r_s2.v        <= r_s1.in.v;
            r_s2.tr       <= r_s1.in.tr;
            r_s2.p        <= r_s1.p;
            r_s2.straight <= r_s1.straight;
            r_s2.sum      <= 20'(r_s1.in.h) + 20'(dh);
            r_s2.hw       <= wrap_q13(20'(r_s1.in.h));
        end
    end

    // stage 3: wrap new heading, fold old heading
    t_s3   r_s3;
    t_fold fold1;
    assign fold1 = fold_q13(r_s2.hw);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3.sd.px       <= r_s2.px;
            r_s3.sd.py       <= r_s2.py;
            r_s3.sd.nh       <= wrap_q13(r_s2.sum);
            r_s3.sd.v        <= r_s2.v;
            r_s3.sd.tr       <= r_s2.tr;
            r_s3.sd.p        <= r_s2.p;
            r_s3.sd.straight <= r_s2.straight;
            r_s3.z1          <= fold1.z;
            r_s3.flip1       <= fold1.flip;
        end
    end

    // stage 4: fold new heading, seed both rotators
    t_cord r_s4;
    t_fold fold2;
    assign fold2 = fold_q13(r_s3.sd.nh);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s4.sd    <= r_s3.sd;
            r_s4.r1.x  <= $signed(TW'(CORDIC_START));
            r_s4.r1.y  <= '0;
            r_s4.r1.z  <= r_s3.z1;
            r_s4.r2.x  <= $signed(TW'(CORDIC_START));
            r_s4.r2.y  <= '0;
            r_s4.r2.z  <= fold2.z;
            r_s4.flip1 <= r_s3.flip1;
            r_s4.flip2 <= fold2.flip;
        end
    end

    // CORDIC rotation stages
    t_cord r_cd   [TRIG_STAGES];
    t_cord cd_src [TRIG_STAGES];
    t_cord n_cd   [TRIG_STAGES];

    for (genvar k = 0; k < TRIG_STAGES; k++) begin : g_cordic
        if (k == 0) begin : g_first
            assign cd_src[k] = r_s4;
        end else begin : g_next
            assign cd_src[k] = r_cd[k-1];
        end

        always_comb begin
            n_cd[k]    = cd_src[k];
            n_cd[k].r1 = rot_step(cd_src[k].r1, k, ATAN_TAB[k]);
            n_cd[k].r2 = rot_step(cd_src[k].r2, k, ATAN_TAB[k]);
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_cd[k] <= n_cd[k];
            end
        end
    end

    // stage E: undo fold, sine and cosine differences
    t_cord                fin;
    logic signed [TW-1:0] c1;
    logic signed [TW-1:0] s1;
    logic signed [TW-1:0] c2;
    logic signed [TW-1:0] s2;
    t_side                r_e_sd;
    logic signed [TW-1:0] r_e_c1;
    logic signed [TW-1:0] r_e_s1;
    logic signed [TW:0]   r_e_ds;
    logic signed [TW:0]   r_e_dc;

    assign fin = r_cd[TRIG_STAGES-1];
    assign c1  = fin.flip1 ? -fin.r1.x : fin.r1.x;
    assign s1  = fin.flip1 ? -fin.r1.y : fin.r1.y;
    assign c2  = fin.flip2 ? -fin.r2.x : fin.r2.x;
    assign s2  = fin.flip2 ? -fin.r2.y : fin.r2.y;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e_sd <= fin.sd;
            r_e_c1 <= c1;
            r_e_s1 <= s1;
            r_e_ds <= (TW+1)'(s2) - (TW+1)'(s1);
            r_e_dc <= (TW+1)'(c1) - (TW+1)'(c2);
        end
    end

    // stage F: products
    t_side              r_f_sd;
    logic signed [PW-1:0] r_f_numx;
    logic signed [PW-1:0] r_f_numy;
    logic signed [MW-1:0] r_f_mx;
    logic signed [MW-1:0] r_f_my;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f_sd   <= r_e_sd;
            r_f_numx <= r_e_sd.v * r_e_ds;
            r_f_numy <= r_e_sd.v * r_e_dc;
            r_f_mx   <= r_e_sd.p * r_e_c1;
            r_f_my   <= r_e_sd.p * r_e_s1;
        end
    end

    // stage G: straight rounding, divider operands
    t_dv                  n_g;
    t_dv                  r_g;
    logic signed [MW-1:0] mx_rnd;
    logic signed [MW-1:0] my_rnd;
    logic signed [DW:0]   den;
    logic [PW-1:0]        absx;
    logic [PW-1:0]        absy;

    always_comb begin
        mx_rnd = (r_f_mx + RND38) >>> 38;
        my_rnd = (r_f_my + RND38) >>> 38;
        den    = (DW+1)'($signed({r_f_sd.tr, 9'b0}));
        absx   = r_f_numx[PW-1] ? PW'(-r_f_numx) : PW'(r_f_numx);
        absy   = r_f_numy[PW-1] ? PW'(-r_f_numy) : PW'(r_f_numy);

        n_g.px       = r_f_sd.px;
        n_g.py       = r_f_sd.py;
        n_g.nh       = r_f_sd.nh;
        n_g.straight = r_f_sd.straight;
        n_g.dxs      = 32'(mx_rnd);
        n_g.dys      = 32'(my_rnd);
        n_g.negx     = r_f_numx[PW-1] ^ r_f_sd.tr[15];
        n_g.negy     = r_f_numy[PW-1] ^ r_f_sd.tr[15];
        n_g.dmag     = den[DW] ? DW'(-den) : DW'(den);
        n_g.qx.rem   = '0;
        n_g.qx.quo   = '0;
        n_g.qx.num   = NW'(absx) + NW'(n_g.dmag >> 1);
        n_g.qy.rem   = '0;
        n_g.qy.quo   = '0;
        n_g.qy.num   = NW'(absy) + NW'(n_g.dmag >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_g <= n_g;
        end
    end

    // restoring divider, one quotient bit per stage
    t_dv r_dv   [NW];
    t_dv dv_src [NW];
    t_dv n_dv   [NW];

    for (genvar k = 0; k < NW; k++) begin : g_div
        if (k == 0) begin : g_first
            assign dv_src[k] = r_g;
        end else begin : g_next
            assign dv_src[k] = r_dv[k-1];
        end

        always_comb begin
            n_dv[k]    = dv_src[k];
            n_dv[k].qx = div_step(dv_src[k].qx, dv_src[k].dmag);
            n_dv[k].qy = div_step(dv_src[k].qy, dv_src[k].dmag);
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dv[k] <= n_dv[k];
            end
        end
    end

    // stage H: sign, path select, position add
    t_dv                  dvo;
    logic signed [NW:0]   qxs;
    logic signed [NW:0]   qys;
    logic signed [NW:0]   dx;
    logic signed [NW:0]   dy;
    logic signed [SW-1:0] r_h_x;
    logic signed [SW-1:0] r_h_y;
    logic signed [15:0]   r_h_nh;

    assign dvo = r_dv[NW-1];

    always_comb begin
        qxs = $signed({1'b0, dvo.qx.quo});
        qys = $signed({1'b0, dvo.qy.quo});
        dx  = dvo.straight ? (NW+1)'(dvo.dxs) : (dvo.negx ? -qxs : qxs);
        dy  = dvo.straight ? (NW+1)'(dvo.dys) : (dvo.negy ? -qys : qys);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_h_x  <= SW'(dvo.px) + SW'(dx);
            r_h_y  <= SW'(dvo.py) + SW'(dy);
            r_h_nh <= dvo.nh;
        end
    end

    // output register: saturate
    logic signed [31:0] r_o_x;
    logic signed [31:0] r_o_y;
    logic signed [15:0] r_o_nh;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_x  <= sat32(r_h_x);
            r_o_y  <= sat32(r_h_y);
            r_o_nh <= r_h_nh;
        end
    end

    assign o_m_axis_tdata = {r_o_nh, r_o_y, r_o_x};

    // folded angles lie within a quarter turn
    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[V_S4] |->
            (r_s4.r1.z <= (TW'(HALF_PI_Q13) <<< 17)) && (r_s4.r1.z >= -(TW'(HALF_PI_Q13) <<< 17))
         && (r_s4.r2.z <= (TW'(HALF_PI_Q13) <<< 17)) && (r_s4.r2.z >= -(TW'(HALF_PI_Q13) <<< 17)))
        else $error("folded angle out of range");

    // divider remainders stay below the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[V_H-1] && (dvo.dmag != '0)) |->
            (dvo.qx.rem < dvo.dmag) && (dvo.qy.rem < dvo.dmag))
        else $error("divider remainder not below divisor");

    // delivered heading is wrapped
    a_heading_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_o_nh >= -16'(PI_Q13)) && (r_o_nh < 16'(PI_Q13)))
        else $error("output heading not wrapped");

endmodule
